@@ sv/mpura_pkg.sv @@
`timescale 1ns / 1ps
package mpura_pkg;

	// Default table depth
	localparam int REGION_COUNT_DEF = 8;

	// Width of the load index field
	localparam int LOAD_IDX_W = 3;

	// Region number reported when nothing matches
	localparam logic [7:0] NO_REGION = 8'hFF;

	// Largest size field that still takes part in matching
	localparam logic [4:0] MAX_SIZE_FIELD = 5'd30;

	// Fault status bit that marks the fault address valid
	localparam int ADDR_VALID_BIT = 7;

	// Item function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// One region entry: base word and attribute word
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] attr;
	} region_entry_t;

	// Write port of the region table
	typedef struct packed {
		logic                  en;
		logic [LOAD_IDX_W-1:0] idx;
		region_entry_t         entry;
	} table_wr_t;

endpackage

@@ sv/mpura_table.sv @@
`timescale 1ns / 1ps
module mpura_table #(
	parameter int REGION_COUNT = mpura_pkg::REGION_COUNT_DEF,
	parameter int IDX_W        = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mpura_pkg::table_wr_t      wr,
	input  logic [IDX_W-1:0]          rd_idx,
	output mpura_pkg::region_entry_t  rd_entry
);
	import mpura_pkg::*;

	localparam int CMP_W = (IDX_W > LOAD_IDX_W) ? IDX_W : LOAD_IDX_W;

	logic [31:0] base_q [REGION_COUNT];
	logic [31:0] attr_q [REGION_COUNT];

	// Clear attribute words on reset so every region starts disabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGION_COUNT; i++) begin
				attr_q[i] <= '0;
			end
		end else if (wr.en) begin
			for (int i = 0; i < REGION_COUNT; i++) begin
				if (CMP_W'(wr.idx) == CMP_W'(i)) begin
					attr_q[i] <= wr.entry.attr;
				end
			end
		end
	end

	// Hold base words; a base only takes part in matching once its region is enabled
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int i = 0; i < REGION_COUNT; i++) begin
				if (CMP_W'(wr.idx) == CMP_W'(i)) begin
					base_q[i] <= wr.entry.base;
				end
			end
		end
	end

	// Read the entry under scan
	always_comb begin
		rd_entry.base = base_q[rd_idx];
		rd_entry.attr = attr_q[rd_idx];
	end

endmodule

@@ sv/mpura_match.sv @@
`timescale 1ns / 1ps
module mpura_match (
	input  logic [31:0]              addr,
	input  mpura_pkg::region_entry_t entry,
	output logic                     hit
);
	import mpura_pkg::*;

	logic [4:0]  size_f;
	logic [31:0] base;
	logic [31:0] diff;
	logic [32:0] limit;

	// Decode the region and test base <= addr < base + size, for an enabled region with size field up to 30
	always_comb begin
		size_f = entry.attr[5:1];
		base   = {entry.base[31:5], 5'b0};
		diff   = addr - base;
		limit  = 33'd1 << (6'(size_f) + 6'd1);
		hit    = entry.attr[0] && (size_f <= MAX_SIZE_FIELD) && (addr >= base)
			&& ({1'b0, diff} < limit);
	end

endmodule

@@ sv/mpu_region_address_match.sv @@
`timescale 1ns / 1ps
// Load beat: the entry is written at the accepting edge and done pulses in the next cycle;
// a new beat may be started in every cycle. Lookup beat: one region is checked per cycle,
// from region 0, by the shared match unit; the scan stops at the first hit or after the last
// region, and done then pulses; busy is high until then.
// The receiver cannot stall: each result is shown for one cycle with done high.
// Reset clears every attribute word (all regions disabled), idles the sequencer, drops done.
module mpu_region_address_match #(
	parameter int REGION_COUNT = mpura_pkg::REGION_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [2:0]  region_index,
	input  logic [31:0] load_base_word,
	input  logic [31:0] load_attr_word,
	input  logic [31:0] fault_address,
	input  logic [31:0] program_counter,
	input  logic [31:0] fault_status,
	output logic        done,
	output logic        match_found,
	output logic [7:0]  region_number,
	output logic [31:0] hit_base_word,
	output logic [31:0] hit_attr_word
);
	import mpura_pkg::*;

	localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [31:0]        addr_q;
	logic               done_q;
	logic               match_q;
	logic [7:0]         number_q;
	logic [31:0]        base_q;
	logic [31:0]        attr_q;

	logic               accept;
	table_wr_t          wr;
	region_entry_t      rd_entry;
	logic               hit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Write port driven straight from a load beat
	always_comb begin
		wr.en         = accept && (func == FUNC_LOAD);
		wr.idx        = region_index;
		wr.entry.base = load_base_word;
		wr.entry.attr = load_attr_word;
	end

	mpura_table #(
		.REGION_COUNT(REGION_COUNT),
		.IDX_W       (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (cnt_q),
		.rd_entry(rd_entry)
	);

	mpura_match u_match (
		.addr (addr_q),
		.entry(rd_entry),
		.hit  (hit)
	);

	// Sequencer: answer a load beat with done, start a scan on a lookup beat, stop at the first hit or the last region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (func == FUNC_LOOKUP) begin
							state_q <= ST_SCAN;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (hit || (cnt_q == LAST_IDX)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the search address and the result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= fault_status[ADDR_VALID_BIT] ? fault_address : program_counter;
			match_q  <= 1'b0;
			number_q <= NO_REGION;
			base_q   <= '0;
			attr_q   <= '0;
		end else if ((state_q == ST_SCAN) && hit) begin
			match_q  <= 1'b1;
			number_q <= 8'(cnt_q);
			base_q   <= rd_entry.base;
			attr_q   <= rd_entry.attr;
		end
	end

	assign done          = done_q;
	assign match_found   = match_q;
	assign region_number = number_q;
	assign hit_base_word = base_q;
	assign hit_attr_word = attr_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while the sequencer is busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted beat neither scanned nor answered");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !match_found) |->
			(region_number == NO_REGION && hit_base_word == '0 && hit_attr_word == '0))
		else $error("miss result carries region data");

	a_hit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(done && match_found) |->
			(hit_attr_word[0] && region_number < 8'(REGION_COUNT)))
		else $error("hit reports a disabled or out-of-range region");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import mpura_pkg::*;

	localparam int N_REGIONS    = REGION_COUNT_DEF;
	localparam int RANDOM_BEATS = 750;
	localparam int CALM_TAIL    = 120;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int DRAIN_CYCLES = 2 * N_REGIONS + 8;
	localparam int MAX_REPORTS  = 100;

	typedef struct packed {
		logic        match;
		logic [7:0]  number;
		logic [31:0] base;
		logic [31:0] attr;
	} match_result_t;

	typedef struct {
		logic          fn;
		logic [2:0]    idx;
		logic [31:0]   load_base;
		logic [31:0]   load_attr;
		logic [31:0]   fault_addr;
		logic [31:0]   pc;
		logic [31:0]   status;
		logic          typed;
		match_result_t want;
	} region_beat_t;

	localparam match_result_t NO_HIT = '{match: 1'b0, number: NO_REGION, base: 32'h0, attr: 32'h0};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [2:0]  region_index;
	logic [31:0] load_base_word;
	logic [31:0] load_attr_word;
	logic [31:0] fault_address;
	logic [31:0] program_counter;
	logic [31:0] fault_status;
	logic        done;
	logic        match_found;
	logic [7:0]  region_number;
	logic [31:0] hit_base_word;
	logic [31:0] hit_attr_word;

	region_entry_t shadow_table [N_REGIONS];
	match_result_t pending_matches [$];
	region_beat_t  directed_beats [$];
	match_result_t oldest_match;
	int            err_count;
	int            cycle_count;

	mpu_region_address_match dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.region_index(region_index),
		.load_base_word(load_base_word),
		.load_attr_word(load_attr_word),
		.fault_address(fault_address),
		.program_counter(program_counter),
		.fault_status(fault_status),
		.done(done),
		.match_found(match_found),
		.region_number(region_number),
		.hit_base_word(hit_base_word),
		.hit_attr_word(hit_attr_word)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (err_count < MAX_REPORTS) begin
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		end
		err_count++;
	endtask

	// Does an entry's aligned window hold the address; size field 31 never does
	function automatic bit region_covers(region_entry_t e, logic [31:0] addr);
		logic [4:0]  sf;
		logic [31:0] lo;
		logic [32:0] span;
		sf = e.attr[5:1];
		if (!e.attr[0] || sf > MAX_SIZE_FIELD) begin
			return 1'b0;
		end
		lo = e.base & 32'hFFFF_FFE0;
		span = 33'd1 << (int'(sf) + 1);
		return addr >= lo && {1'b0, addr - lo} < span;
	endfunction

	// Apply one beat to the shadow table and give the lowest-numbered hit
	function automatic match_result_t match_region_table(region_beat_t b);
		match_result_t r;
		logic [31:0]   addr;
		r = NO_HIT;
		if (b.fn == FUNC_LOAD) begin
			if (b.idx < N_REGIONS) begin
				shadow_table[b.idx] = '{base: b.load_base, attr: b.load_attr};
			end
			return r;
		end
		addr = b.status[ADDR_VALID_BIT] ? b.fault_addr : b.pc;
		for (int i = 0; i < N_REGIONS; i++) begin
			if (region_covers(shadow_table[i], addr)) begin
				r = '{1'b1, 8'(i), shadow_table[i].base, shadow_table[i].attr};
				return r;
			end
		end
		return r;
	endfunction

	// Directed load: lookup fields carry noise, result is always the empty one
	function automatic region_beat_t load_row(logic [2:0] idx, logic [31:0] base,
			logic [31:0] attr);
		region_beat_t b;
		b = '{FUNC_LOAD, idx, base, attr, $urandom(), $urandom(), $urandom(), 1'b1, NO_HIT};
		return b;
	endfunction

	// Directed lookup: load fields carry noise
	function automatic region_beat_t lookup_row(logic [31:0] fa, logic [31:0] pc,
			logic [31:0] fs, logic typed, match_result_t want);
		region_beat_t b;
		b = '{FUNC_LOOKUP, 3'($urandom()), $urandom(), $urandom(), fa, pc, fs, typed, want};
		return b;
	endfunction

	// Aim mostly inside or just around a loaded window, sometimes anywhere
	function automatic logic [31:0] pick_search_address();
		region_entry_t e;
		logic [31:0]   lo;
		logic [32:0]   span;
		logic [32:0]   span_mask;
		int            mode;
		e = shadow_table[$urandom_range(0, N_REGIONS - 1)];
		lo = e.base & 32'hFFFF_FFE0;
		span = 33'd1 << (int'(e.attr[5:1]) + 1);
		span_mask = span - 1;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			return lo + ($urandom() & span_mask[31:0]);
		end else if (mode == 6) begin
			return lo - 32'd1;
		end else if (mode == 7) begin
			return lo + span[31:0];
		end else if (mode == 8) begin
			return lo + span[31:0] - 32'd1;
		end
		return $urandom();
	endfunction

	function automatic region_beat_t make_random_beat();
		region_beat_t b;
		logic [31:0]  addr;
		int           roll;
		roll = $urandom_range(0, 99);
		b.fn = (roll < 38) ? FUNC_LOAD : FUNC_LOOKUP;
		b.idx = 3'($urandom());
		b.load_base = $urandom();
		b.load_attr = $urandom();
		b.fault_addr = $urandom();
		b.pc = $urandom();
		b.status = $urandom();
		b.typed = 1'b0;
		b.want = NO_HIT;
		if (b.fn == FUNC_LOAD) begin
			// favour small windows so that several regions stay reachable
			roll = $urandom_range(0, 9);
			if (roll < 6) begin
				b.load_attr[5:1] = 5'($urandom_range(0, 12));
			end else if (roll < 8) begin
				b.load_attr[5:1] = 5'($urandom_range(24, 31));
			end
			b.load_attr[0] = ($urandom_range(0, 9) != 0);
		end else begin
			addr = pick_search_address();
			if (b.status[ADDR_VALID_BIT]) begin
				b.fault_addr = addr;
			end else begin
				b.pc = addr;
			end
		end
		return b;
	endfunction

	// Hold idle for the given gap, then present one beat and wait for it to be taken
	task automatic drive_beat(region_beat_t b, int gap);
		match_result_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		func <= b.fn;
		region_index <= b.idx;
		load_base_word <= b.load_base;
		load_attr_word <= b.load_attr;
		fault_address <= b.fault_addr;
		program_counter <= b.pc;
		fault_status <= b.status;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = match_region_table(b);
		pending_matches.push_back(b.typed ? b.want : predicted);
	endtask

	// Check each result beat against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_matches.size() == 0) begin
				report_mismatch("result beat with none pending", 32'(region_number),
					32'(NO_REGION));
			end else begin
				oldest_match = pending_matches.pop_front();
				if (match_found !== oldest_match.match)
					report_mismatch("match_found", 32'(match_found), 32'(oldest_match.match));
				if (region_number !== oldest_match.number)
					report_mismatch("region_number", 32'(region_number),
						32'(oldest_match.number));
				if (hit_base_word !== oldest_match.base)
					report_mismatch("hit_base_word", hit_base_word, oldest_match.base);
				if (hit_attr_word !== oldest_match.attr)
					report_mismatch("hit_attr_word", hit_attr_word, oldest_match.attr);
			end
		end
	end

	// Cycle counter guarding against a hang
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		bit idle_on;
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_LOAD;
		region_index = '0;
		load_base_word = '0;
		load_attr_word = '0;
		fault_address = '0;
		program_counter = '0;
		fault_status = '0;
		err_count = 0;
		foreach (shadow_table[i]) shadow_table[i] = '{base: 32'h0, attr: 32'h0};

		// empty table: both address sources miss
		directed_beats.push_back(lookup_row(32'h0, 32'h0, 32'h0000_0080, 1'b1, NO_HIT));
		directed_beats.push_back(lookup_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FF7F, 1'b1, NO_HIT));
		// largest window from zero, low base bits stored but not matched
		directed_beats.push_back(load_row(3'd0, 32'h0000_001F, 32'h0000_003D));
		directed_beats.push_back(lookup_row(32'h7FFF_FFFF, 32'h0, 32'h0000_0080, 1'b1,
			'{1'b1, 8'd0, 32'h0000_001F, 32'h0000_003D}));
		directed_beats.push_back(lookup_row(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_HIT));
		// size field of 31 never matches
		directed_beats.push_back(load_row(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed_beats.push_back(lookup_row(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, NO_HIT));
		// disabled entry with every other attribute bit set
		directed_beats.push_back(load_row(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
		directed_beats.push_back(lookup_row(32'h0000_0010, 32'h0, 32'h0000_0080, 1'b0, NO_HIT));
		// top window, subregion bits ignored
		directed_beats.push_back(load_row(3'd7, 32'hFFFF_FFE0, 32'h0000_FF09));
		directed_beats.push_back(lookup_row(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, NO_HIT));
		directed_beats.push_back(lookup_row(32'h0, 32'hFFFF_FFDF, 32'h0, 1'b0, NO_HIT));
		// overlap: lower region number wins
		directed_beats.push_back(load_row(3'd3, 32'hFFFF_FFC0, 32'h0000_000B));
		directed_beats.push_back(lookup_row(32'hFFFF_FFE0, 32'h0, 32'h0000_0080, 1'b0, NO_HIT));
		// two-byte window and its edges
		directed_beats.push_back(load_row(3'd5, 32'h2000_0001, 32'h0000_0001));
		directed_beats.push_back(lookup_row(32'h2000_0001, 32'h0, 32'h0000_0080, 1'b0, NO_HIT));
		directed_beats.push_back(lookup_row(32'h2000_0002, 32'h0, 32'h0000_0080, 1'b0, NO_HIT));
		directed_beats.push_back(lookup_row(32'h1FFF_FFFF, 32'h0, 32'h0000_0080, 1'b0, NO_HIT));
		directed_beats.push_back(load_row(3'd1, 32'h0000_0000, 32'h0000_003D));
		directed_beats.push_back(lookup_row(32'h2000_0000, 32'h0, 32'h0000_0080, 1'b0, NO_HIT));
		directed_beats.push_back(load_row(3'd2, 32'h8000_0000, 32'h0000_003D));
		// valid bit clear: program counter searched, fault address ignored, then the reverse
		directed_beats.push_back(lookup_row(32'h0, 32'h8000_0000, 32'h0, 1'b0, NO_HIT));
		directed_beats.push_back(lookup_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_HIT));
		directed_beats.push_back(load_row(3'd4, 32'h1234_5678, 32'hAAAA_AAAB));
		directed_beats.push_back(load_row(3'd6, 32'hDEAD_BEEF, 32'h0000_0000));

		// hold reset, then release away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_beats[k]) begin
			drive_beat(directed_beats[k], (k % 5 == 2) ? $urandom_range(1, 18) : 0);
		end

		// random beats, idle bursts switched on and off in stretches, none near the end
		idle_on = 1'b0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
			gap = 0;
			if (n < RANDOM_BEATS - CALM_TAIL && idle_on && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 18);
			end
			drive_beat(make_random_beat(), gap);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain, then give stray results a chance to show
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
